@@ src/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge once reset is released.
`define MCODO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define MCODO_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/mcodo_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mcodo_pkg;

    // CORDIC iteration count, legal range 12..32
    localparam int unsigned CORDIC_STEPS = 24;
    localparam int unsigned CORDIC_IW    = $clog2(CORDIC_STEPS);
    // 1/K gain compensation in Q2.30
    localparam logic signed [33:0] CORDIC_START_X = 34'sd652032874;

    // atan(2^-i) as a binary angle, 2^32 per turn
    localparam logic [31:0] ATAN_LUT [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // shared multiply-accumulate unit widths
    localparam int unsigned MAC_AW   = 35;
    localparam int unsigned MAC_BW   = 17;
    localparam int unsigned MAC_PW   = MAC_AW + MAC_BW;
    localparam int unsigned MAC_ACCW = 68;

    // products per scaled value and per rotated coordinate
    localparam int unsigned MUL_PARTS = 2;
    localparam int unsigned ROT_PARTS = 4;

    // configuration register indexes
    localparam int unsigned CFG_IW = 2;
    localparam logic [CFG_IW-1:0] CFG_METRE_GAIN = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_TURN_GAIN  = 2'd1;

    typedef struct packed {
        logic clear;   // zero the accumulator
        logic issue;   // start a product this cycle
        logic hi;      // product weighs 2^16
        logic sub;     // subtract the product
    } mac_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUMS,
        ST_MUL_X,
        ST_SAT_X,
        ST_MUL_Y,
        ST_SAT_Y,
        ST_MUL_YAW,
        ST_YAW,
        ST_CORDIC,
        ST_ROT_X,
        ST_POSE_X,
        ST_ROT_Y,
        ST_POSE_Y,
        ST_DONE
    } mcodo_state_t;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -40'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/mcodo_mac.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mcodo_mac
    import mcodo_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  mac_ctl_t                   ctl,
    input  logic signed [MAC_AW-1:0]   a,
    input  logic signed [MAC_BW-1:0]   b,
    output logic signed [MAC_ACCW-1:0] acc
);

    logic signed [MAC_PW-1:0]   prod_reg;
    logic                       pvalid_reg;
    logic                       phi_reg;
    logic                       psub_reg;
    logic signed [MAC_ACCW-1:0] acc_reg;
    logic signed [MAC_ACCW-1:0] acc_next;
    logic signed [MAC_ACCW-1:0] term;

    // product stage
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvalid_reg <= 1'b0;
            phi_reg    <= 1'b0;
            psub_reg   <= 1'b0;
        end
        else
        begin
            pvalid_reg <= ctl.issue;
            phi_reg    <= ctl.hi;
            psub_reg   <= ctl.sub;
        end
    end

    // accumulate stage: weigh by 1 or 2^16, add or subtract
    assign term = phi_reg ? {prod_reg, 16'b0}
                          : {{(MAC_ACCW - MAC_PW){prod_reg[MAC_PW-1]}}, prod_reg};

    always_comb
    begin
        if (ctl.clear)
            acc_next = '0;
        else if (pvalid_reg)
            acc_next = psub_reg ? acc_reg - term : acc_reg + term;
        else
            acc_next = acc_reg;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

@@ src/mcodo_cordic.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mcodo_cordic
    import mcodo_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic        [31:0] angle,
    output logic               done,
    output logic signed [32:0] cos_out,
    output logic signed [32:0] sin_out
);

    logic signed [33:0]   x_reg;
    logic signed [33:0]   y_reg;
    logic signed [33:0]   z_reg;
    logic [CORDIC_IW-1:0] step_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic                 flip_reg;

    logic                 flip_w;
    logic [31:0]          folded;
    logic signed [33:0]   xs;
    logic signed [33:0]   ys;
    logic signed [33:0]   atan_w;
    logic signed [33:0]   neg_x;
    logic signed [33:0]   neg_y;
    logic                 last_w;

    // fold the second and third quarter turns onto the first and fourth
    assign flip_w = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
    assign folded = flip_w ? {~angle[31], angle[30:0]} : angle;

    assign xs     = x_reg >>> step_reg;
    assign ys     = y_reg >>> step_reg;
    assign atan_w = {2'b00, ATAN_LUT[5'(step_reg)]};
    assign last_w = (step_reg == CORDIC_IW'(CORDIC_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_w;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (last_w)
                    busy_reg <= 1'b0;
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= CORDIC_START_X;
            y_reg    <= '0;
            z_reg    <= {{2{folded[31]}}, folded};
            flip_reg <= flip_w;
        end
        else if (busy_reg)
        begin
            // rotate toward zero residual angle
            if (!z_reg[33])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_w;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_w;
            end
        end
    end

    assign neg_x   = -x_reg;
    assign neg_y   = -y_reg;
    assign cos_out = flip_reg ? neg_x[32:0] : x_reg[32:0];
    assign sin_out = flip_reg ? neg_y[32:0] : y_reg[32:0];
    assign done    = done_reg;

endmodule

`default_nettype wire

@@ src/mecanum_encoder_odometry.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Mecanum wheel odometry. Each request carries four raw 32-bit encoder counts
// (or, with tuser set, a command to clear the stored counts and the pose) and
// yields one result: the pose after the update as Q16.16 x and y in metres,
// saturating, and a 32-bit binary-angle heading that wraps once per turn. An
// update runs 14 partial products through the one 35x17 multiply-accumulate unit
// (the two body displacements, the yaw change and the rotation into the world
// frame, each group of products followed by a step to drain the pipe and a step
// to saturate or store the result) and CORDIC_STEPS iterations of the shift-add
// CORDIC that gives the sine and cosine of the midpoint heading. A request waits
// in its last state until the previous result has been taken. The result sits in
// an output register, so the next request is taken while it waits.
// Gains are written through cfg_we/cfg_index/cfg_data; the user must write them
// only while the block is idle, which the block itself does not enforce. Writes
// to indexes past the turn gain are dropped.
module mecanum_encoder_odometry
    import mcodo_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // count_wheel0 [31:0], count_wheel1 [63:32], count_wheel2 [95:64],
    // count_wheel3 [127:96]
    input  logic [127:0]      s_axis_tdata,
    // op [0]
    input  logic              s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // pos_x [31:0], pos_y [63:32], heading [95:64]
    output logic [95:0]       m_axis_tdata,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [31:0]       cfg_data
);

    mcodo_state_t state_reg;
    mcodo_state_t state_next;
    logic [2:0]   step_reg;
    logic [2:0]   step_next;

    logic [31:0]        gain_m_reg;
    logic [31:0]        gain_t_reg;
    logic [31:0]        last_reg [4];
    logic signed [31:0] pose_x_reg;
    logic signed [31:0] pose_y_reg;
    logic [31:0]        head_reg;
    logic               out_valid_reg;
    logic [95:0]        out_reg;

    logic signed [31:0] delta_reg [4];
    logic signed [34:0] sum_x_reg;
    logic signed [34:0] sum_y_reg;
    logic signed [34:0] sum_r_reg;
    logic signed [31:0] dx_reg;
    logic signed [31:0] dy_reg;
    logic [31:0]        dyaw_reg;

    logic [31:0]        cnt_in [4];
    logic signed [34:0] dext [4];
    logic               in_acc;
    logic               out_load;

    mac_ctl_t                   mac_ctl;
    logic signed [MAC_AW-1:0]   mac_a;
    logic signed [MAC_BW-1:0]   mac_b;
    logic signed [MAC_ACCW-1:0] mac_acc;

    logic               cordic_start;
    logic [31:0]        cordic_angle;
    logic               cordic_done;
    logic signed [32:0] cos_w;
    logic signed [32:0] sin_w;

    logic signed [34:0] mag_src;
    logic signed [34:0] mag_w;
    logic signed [32:0] trig_w;
    logic               use_sin;
    logic [35:0]        scaled_w;
    logic signed [39:0] scaled_s;
    logic signed [39:0] pose_sum_x;
    logic signed [39:0] pose_sum_y;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            cnt_in[i] = s_axis_tdata[32*i +: 32];
            dext[i]   = {{3{delta_reg[i][31]}}, delta_reg[i]};
        end
    end

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

    // magnitude of the body sum being scaled; the sign is put back before saturation
    assign mag_src = (state_reg == ST_MUL_Y) ? sum_y_reg : sum_x_reg;
    assign mag_w   = mag_src[34] ? -mag_src : mag_src;

    // x row takes cos then sin, y row takes sin then cos
    assign use_sin = (state_reg == ST_ROT_X) ? step_reg[1] : !step_reg[1];
    assign trig_w  = use_sin ? sin_w : cos_w;

    // truncation toward zero of sum * gain / 2^32
    assign scaled_w = mac_acc[67:32];
    assign scaled_s = {4'b0000, scaled_w};

    // midpoint heading: old heading plus half the yaw change, floored
    assign cordic_angle = head_reg + {mac_acc[47], mac_acc[47:17]};

    assign pose_sum_x = {{8{pose_x_reg[31]}}, pose_x_reg} + {{2{mac_acc[67]}}, mac_acc[67:30]};
    assign pose_sum_y = {{8{pose_y_reg[31]}}, pose_y_reg} + {{2{mac_acc[67]}}, mac_acc[67:30]};

    // ---------------------------------------------------------------
    // sequencer: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        step_next  = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                    state_next = s_axis_tuser ? ST_DONE : ST_SUMS;
            end
            ST_SUMS:
                state_next = ST_MUL_X;
            ST_MUL_X:
            begin
                if (step_reg == 3'(MUL_PARTS))
                    state_next = ST_SAT_X;
                else
                    step_next = step_reg + 3'd1;
            end
            ST_SAT_X:
                state_next = ST_MUL_Y;
            ST_MUL_Y:
            begin
                if (step_reg == 3'(MUL_PARTS))
                    state_next = ST_SAT_Y;
                else
                    step_next = step_reg + 3'd1;
            end
            ST_SAT_Y:
                state_next = ST_MUL_YAW;
            ST_MUL_YAW:
            begin
                if (step_reg == 3'(MUL_PARTS))
                    state_next = ST_YAW;
                else
                    step_next = step_reg + 3'd1;
            end
            ST_YAW:
                state_next = ST_CORDIC;
            ST_CORDIC:
            begin
                if (cordic_done)
                    state_next = ST_ROT_X;
            end
            ST_ROT_X:
            begin
                if (step_reg == 3'(ROT_PARTS))
                    state_next = ST_POSE_X;
                else
                    step_next = step_reg + 3'd1;
            end
            ST_POSE_X:
                state_next = ST_ROT_Y;
            ST_ROT_Y:
            begin
                if (step_reg == 3'(ROT_PARTS))
                    state_next = ST_POSE_Y;
                else
                    step_next = step_reg + 3'd1;
            end
            ST_POSE_Y:
                state_next = ST_DONE;
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer: unit controls and operand selection
    // ---------------------------------------------------------------
    always_comb
    begin
        s_axis_tready = 1'b0;
        cordic_start  = 1'b0;
        mac_ctl       = '0;
        mac_a         = '0;
        mac_b         = '0;
        unique case (state_reg)
            ST_IDLE:
                s_axis_tready = 1'b1;
            ST_MUL_X, ST_MUL_Y:
            begin
                // |sum| * gain, low half then high half of the gain
                mac_ctl.clear = (step_reg == 3'd0);
                mac_ctl.issue = (step_reg < 3'(MUL_PARTS));
                mac_ctl.hi    = step_reg[0];
                mac_a         = mag_w;
                mac_b         = step_reg[0] ? {1'b0, gain_m_reg[31:16]}
                                            : {1'b0, gain_m_reg[15:0]};
            end
            ST_MUL_YAW:
            begin
                mac_ctl.clear = (step_reg == 3'd0);
                mac_ctl.issue = (step_reg < 3'(MUL_PARTS));
                mac_ctl.hi    = step_reg[0];
                mac_a         = sum_r_reg;
                mac_b         = step_reg[0] ? {1'b0, gain_t_reg[31:16]}
                                            : {1'b0, gain_t_reg[15:0]};
            end
            ST_YAW:
                cordic_start = 1'b1;
            ST_ROT_X, ST_ROT_Y:
            begin
                // dx * trig, then dy * trig; x row subtracts the dy terms
                mac_ctl.clear = (step_reg == 3'd0);
                mac_ctl.issue = (step_reg < 3'(ROT_PARTS));
                mac_ctl.hi    = step_reg[0];
                mac_ctl.sub   = (state_reg == ST_ROT_X) && step_reg[1];
                mac_a         = step_reg[1] ? {{3{dy_reg[31]}}, dy_reg}
                                            : {{3{dx_reg[31]}}, dx_reg};
                mac_b         = step_reg[0] ? trig_w[32:16] : {1'b0, trig_w[15:0]};
            end
            default:
            begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // control and architectural state
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            gain_m_reg    <= '0;
            gain_t_reg    <= '0;
            pose_x_reg    <= '0;
            pose_y_reg    <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
                last_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_METRE_GAIN: gain_m_reg <= cfg_data;
                    CFG_TURN_GAIN:  gain_t_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            if (in_acc)
            begin
                if (s_axis_tuser)
                begin
                    // clear request: drop the stored counts and the pose
                    pose_x_reg <= '0;
                    pose_y_reg <= '0;
                    head_reg   <= '0;
                    for (int i = 0; i < 4; i++)
                        last_reg[i] <= '0;
                end
                else
                begin
                    for (int i = 0; i < 4; i++)
                        last_reg[i] <= cnt_in[i];
                end
            end

            if (state_reg == ST_POSE_X)
                pose_x_reg <= sat32(pose_sum_x);

            if (state_reg == ST_POSE_Y)
            begin
                pose_y_reg <= sat32(pose_sum_y);
                head_reg   <= head_reg + dyaw_reg;
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // working registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_acc && !s_axis_tuser)
        begin
            // wrapping deltas against the counts seen last time
            for (int i = 0; i < 4; i++)
                delta_reg[i] <= cnt_in[i] - last_reg[i];
        end

        if (state_reg == ST_SUMS)
        begin
            sum_x_reg <= -dext[0] + dext[1] - dext[2] + dext[3];
            sum_y_reg <=  dext[0] + dext[1] + dext[2] + dext[3];
            sum_r_reg <=  dext[0] - dext[1] - dext[2] + dext[3];
        end

        if (state_reg == ST_SAT_X)
            dx_reg <= sat32(sum_x_reg[34] ? -scaled_s : scaled_s);

        if (state_reg == ST_SAT_Y)
            dy_reg <= sat32(sum_y_reg[34] ? -scaled_s : scaled_s);

        if (state_reg == ST_YAW)
            dyaw_reg <= mac_acc[47:16];

        if (out_load)
            out_reg <= {head_reg, pose_y_reg, pose_x_reg};
    end

    mcodo_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a     (mac_a),
        .b     (mac_b),
        .acc   (mac_acc)
    );

    mcodo_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .angle   (cordic_angle),
        .done    (cordic_done),
        .cos_out (cos_w),
        .sin_out (sin_w)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

endmodule

`default_nettype wire

@@ src/mcodo_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mcodo_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [95:0] m_axis_tdata
);

    // no result is offered while reset is held
    `MCODO_ASSERT_ALWAYS(a_no_result_in_reset, !rst_n |-> !m_axis_tvalid, "result valid in reset")

    // one request at a time: the block is busy right after taking one
    `MCODO_ASSERT(a_busy_after_request, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "request taken while busy")

    // a stalled result holds
    `MCODO_ASSERT(a_result_holds, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")

    // a clear request taken while the output is free reports an all-zero pose
    `MCODO_ASSERT(a_clear_reports_zero, (s_axis_tvalid && s_axis_tready && s_axis_tuser && (!m_axis_tvalid || m_axis_tready)) |=> ##1 (m_axis_tvalid && (m_axis_tdata == 96'd0)), "clear request did not report zero pose")

endmodule

bind mecanum_encoder_odometry mcodo_checker u_mcodo_checker (.*);

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import mcodo_pkg::*;

    // request kinds carried on s_axis_tuser
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // register indexes past the turn gain; the block drops writes to them
    localparam logic [CFG_IW-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_SPARE_B = 2'd3;

    localparam int unsigned UPDATE_LATENCY = 28 + CORDIC_STEPS;
    localparam int unsigned RX_HOLD_CYCLES = 400;
    localparam int unsigned PHASE_ITEMS    = 140;
    localparam int unsigned IDLE_PCT       = 26;
    localparam int unsigned REPORT_LIMIT   = 10;

    // packed so that pos_x sits in the lowest bits, as on m_axis_tdata
    typedef struct packed {
        logic [31:0]        heading;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } pose_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // count_wheel0 [31:0], count_wheel1 [63:32], count_wheel2 [95:64],
    // count_wheel3 [127:96]
    logic [127:0] s_axis_tdata;
    // op [0]
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // pos_x [31:0], pos_y [63:32], heading [95:64]
    logic [95:0]  m_axis_tdata;
    logic              cfg_we;
    logic [CFG_IW-1:0] cfg_index;
    logic [31:0]       cfg_data;

    // predicted state of the odometry
    logic [31:0]        metre_gain = '0;
    logic [31:0]        turn_gain = '0;
    logic [31:0]        odo_last_count [4];
    logic signed [31:0] odo_x;
    logic signed [31:0] odo_y;
    logic [31:0]        odo_heading;

    // poses still owed by the block, oldest first
    pose_t pending_pose [$];
    int unsigned mismatch_count = 0;

    // free-running encoder positions that the stimulus walks around
    logic [31:0] enc_count [4];

    // traffic shaping shared by sender and receiver
    bit idle_on = 1'b0;
    bit rx_hold_req = 1'b0;

    mecanum_encoder_odometry dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit: far beyond the slowest legal run of all phases.
    initial
    begin
        #10ms;
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // sum * gain / 2^32, truncated toward zero; done on the magnitude with the
    // gain split in halves so that the low half is dropped the same way
    function automatic longint scale_by_metre_gain(input longint sum, input logic [31:0] g);
        logic [63:0] mag;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] r;
        mag = (sum < 0) ? 64'(-sum) : 64'(sum);
        hi  = mag * {48'd0, g[31:16]};
        lo  = mag * {48'd0, g[15:0]};
        r   = (hi + (lo >> 16)) >> 16;
        return (sum < 0) ? -longint'(r) : longint'(r);
    endfunction

    // Shift-add CORDIC in Q2.30. Fold the angle into the right half plane
    // first and negate both results when folded.
    function automatic void cordic_sin_cos(input logic [31:0] angle,
                                           output longint cos_q, output longint sin_q);
        logic [31:0] a;
        logic        folded;
        longint      x;
        longint      y;
        longint      z;
        longint      xs;
        longint      ys;
        a      = angle;
        folded = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
        if (folded)
            a = a + 32'h8000_0000;
        z = longint'($signed(a));
        x = longint'(CORDIC_START_X);
        y = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'({32'd0, ATAN_LUT[i]});
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'({32'd0, ATAN_LUT[i]});
            end
        end
        cos_q = folded ? -x : x;
        sin_q = folded ? -y : y;
    endfunction

    // Apply one request to the predicted pose and return the pose reported.
    function automatic pose_t advance_pose(input logic op, input logic [127:0] counts);
        longint      d [4];
        longint      sum_x;
        longint      sum_y;
        longint      sum_rot;
        longint      dx;
        longint      dy;
        longint      c;
        longint      s;
        logic [31:0] now;
        logic [31:0] dyaw;
        logic [31:0] mid;
        logic [63:0] yaw_prod;
        pose_t       r;
        if (op == OP_CLEAR)
        begin
            for (int k = 0; k < 4; k++)
                odo_last_count[k] = '0;
            odo_x       = '0;
            odo_y       = '0;
            odo_heading = '0;
        end
        else
        begin
            // wrapping deltas: a count passing the signed limit moves a little
            for (int k = 0; k < 4; k++)
            begin
                now  = counts[32*k +: 32];
                d[k] = longint'($signed(now - odo_last_count[k]));
                odo_last_count[k] = now;
            end
            sum_x   = -d[0] + d[1] - d[2] + d[3];
            sum_y   =  d[0] + d[1] + d[2] + d[3];
            sum_rot =  d[0] - d[1] - d[2] + d[3];
            dx = clamp32(scale_by_metre_gain(sum_x, metre_gain));
            dy = clamp32(scale_by_metre_gain(sum_y, metre_gain));
            // yaw change keeps bits 47:16 of the product, modulo one turn
            yaw_prod = 64'(sum_rot) * {32'd0, turn_gain};
            dyaw     = yaw_prod[47:16];
            // rotate by the heading halfway through the move
            mid = odo_heading + {dyaw[31], dyaw[31:1]};
            cordic_sin_cos(mid, c, s);
            odo_x = clamp32(longint'(odo_x) + ((dx * c - dy * s) >>> 30));
            odo_y = clamp32(longint'(odo_y) + ((dx * s + dy * c) >>> 30));
            odo_heading = odo_heading + dyaw;
        end
        r.x       = odo_x;
        r.y       = odo_y;
        r.heading = odo_heading;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
    endtask

    // Compare every taken result with the oldest pending pose.
    always @(posedge clk)
    begin : check_result
        pose_t got;
        pose_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pending_pose.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("result with no request pending: %h", m_axis_tdata);
            end
            else
            begin
                want = pending_pose.pop_front();
                if (got.x !== want.x)
                    note_mismatch("pos_x", want.x, got.x);
                if (got.y !== want.y)
                    note_mismatch("pos_y", want.y, got.y);
                if (got.heading !== want.heading)
                    note_mismatch("heading", want.heading, got.heading);
            end
        end
    end

    // Receiver: random stalls, a long hold-off on request, and no random stalls
    // while idling is switched off.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge clk);
                rx_hold_req = 1'b0;
            end
            m_axis_tready <= (idle_on && $urandom_range(0, 99) < IDLE_PCT) ? 1'b0 : 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sender and register access
    // ------------------------------------------------------------------

    // Offer one request, wait for the handshake, then log its predicted pose.
    // Valid stays high on return; the next request or stop_sending decides.
    task automatic send_request(input logic op, input logic [127:0] counts);
        pose_t want;
        @(negedge clk);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= counts;
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        want = advance_pose(op, counts);
        pending_pose.push_back(want);
    endtask

    task automatic send_counts(input logic op);
        send_request(op, {enc_count[3], enc_count[2], enc_count[1], enc_count[0]});
    endtask

    task automatic stop_sending();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // Hold the sender until every pending pose has come back, then let the
    // block settle.
    task automatic wait_drained();
        stop_sending();
        while (pending_pose.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_METRE_GAIN)
            metre_gain = val;
        else if (idx == CFG_TURN_GAIN)
            turn_gain = val;
    endtask

    task automatic set_gains(input logic [31:0] metre, input logic [31:0] turn);
        wait_drained();
        write_reg(CFG_METRE_GAIN, metre);
        write_reg(CFG_TURN_GAIN, turn);
    endtask

    // Mostly plausible encoder motion; now and then a large move, an arbitrary
    // count, a limit value or a clear.
    task automatic send_random_request();
        logic op;
        int unsigned mode;
        op = ($urandom_range(0, 29) == 0) ? OP_CLEAR : OP_UPDATE;
        for (int k = 0; k < 4; k++)
        begin
            mode = $urandom_range(0, 9);
            if (mode <= 5)
                enc_count[k] = enc_count[k] + $urandom_range(0, 4000) - 2000;
            else if (mode <= 7)
                enc_count[k] = enc_count[k] + $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            else if (mode == 8)
                enc_count[k] = $urandom();
            else
                case ($urandom_range(0, 3))
                    0: enc_count[k] = 32'h0000_0000;
                    1: enc_count[k] = 32'h7FFF_FFFF;
                    2: enc_count[k] = 32'h8000_0000;
                    default: enc_count[k] = 32'hFFFF_FFFF;
                endcase
        end
        send_counts(op);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Gains are zero out of reset: the pose must stay at the origin.
    task automatic test_zero_gain();
        for (int k = 0; k < 4; k++)
            enc_count[k] = 32'h7FFF_FFFF;
        send_counts(OP_UPDATE);
        for (int k = 0; k < 4; k++)
            enc_count[k] = 32'h8000_0000;
        send_counts(OP_UPDATE);
        for (int k = 0; k < 4; k++)
            enc_count[k] = 32'hFFFF_FFFF;
        send_counts(OP_UPDATE);
        for (int k = 0; k < 4; k++)
            enc_count[k] = $urandom();
        send_counts(OP_UPDATE);
    endtask

    // Writes past the last register must leave both gains alone.
    task automatic test_spare_index();
        set_gains(32'h0123_4567, 32'h0002_8000);
        write_reg(CFG_SPARE_A, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_B, 32'hFFFF_FFFF);
        for (int n = 0; n < 2; n++)
        begin
            enc_count[0] = enc_count[0] + 32'd1500;
            enc_count[1] = enc_count[1] - 32'd700;
            enc_count[2] = enc_count[2] + 32'd90;
            enc_count[3] = enc_count[3] + 32'd2200;
            send_counts(OP_UPDATE);
        end
    endtask

    // Counts that cross the signed and the unsigned limit give small deltas.
    task automatic test_counter_wrap();
        for (int k = 0; k < 4; k++)
            enc_count[k] = 32'h7FFF_FFF0 + 32'(k * k * 5);
        send_counts(OP_UPDATE);
        for (int k = 0; k < 4; k++)
            enc_count[k] = 32'h8000_0010 + 32'(k * 7);
        send_counts(OP_UPDATE);
        for (int k = 0; k < 4; k++)
            enc_count[k] = 32'hFFFF_FFF0 - 32'(k * 3);
        send_counts(OP_UPDATE);
        for (int k = 0; k < 4; k++)
            enc_count[k] = 32'h0000_0010 + 32'(k * 11);
        send_counts(OP_UPDATE);
    endtask

    // Half a turn per update: the midpoint heading swings between opposite sides
    // of the circle and the heading wraps past a full turn.
    task automatic test_heading_wrap();
        set_gains(32'h0800_0000, 32'h4000_0000);
        for (int n = 0; n < 3; n++)
        begin
            enc_count[0] = enc_count[0] + 32'h0000_8000;
            enc_count[1] = enc_count[1] - 32'h0000_8000 + 32'(n * 1000);
            enc_count[2] = enc_count[2] - 32'h0000_8000;
            enc_count[3] = enc_count[3] + 32'h0000_8000;
            send_counts(OP_UPDATE);
        end
    endtask

    // Largest gain and deltas near the limits drive x into both rails.
    task automatic test_pose_saturation();
        set_gains(32'hFFFF_FFFF, 32'h0000_0000);
        send_counts(OP_CLEAR);
        // wheels 0 and 2 step by -2^31, wheels 1 and 3 by 2^31 - 1: x grows
        for (int n = 1; n <= 3; n++)
        begin
            enc_count[0] = (n % 2) ? 32'h8000_0000 : 32'h0000_0000;
            enc_count[2] = enc_count[0];
            enc_count[1] = 32'(n) * 32'h7FFF_FFFF;
            enc_count[3] = enc_count[1];
            send_counts(OP_UPDATE);
        end
        // swap the roles: x falls to the negative rail
        for (int n = 1; n <= 3; n++)
        begin
            enc_count[0] = enc_count[0] + 32'h7FFF_FFFF;
            enc_count[2] = enc_count[0];
            enc_count[1] = enc_count[1] + 32'h8000_0000;
            enc_count[3] = enc_count[1];
            send_counts(OP_UPDATE);
        end
    endtask

    // Clear ignores the counts on the bus and zeroes stored counts and pose.
    task automatic test_clear();
        for (int n = 0; n < 2; n++)
        begin
            for (int k = 0; k < 4; k++)
                enc_count[k] = $urandom();
            send_counts(OP_CLEAR);
        end
        for (int k = 0; k < 4; k++)
            enc_count[k] = 32'(k * 100) + 32'd25;
        send_counts(OP_UPDATE);
    endtask

    // Stall the result side for a long stretch while requests keep coming, so
    // the output register fills and the input stalls.
    task automatic test_backpressure();
        set_gains($urandom(), $urandom());
        idle_on = 1'b0;
        rx_hold_req = 1'b1;
        repeat (8) send_random_request();
        wait_drained();
    endtask

    // Random traffic under a series of gain settings, extremes included. One
    // phase runs with no idling on either side.
    task automatic test_random_traffic();
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: set_gains(32'h0000_0000, 32'h0000_0000);
                1: set_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF);
                2: set_gains($urandom(), $urandom());
                3: set_gains($urandom_range(0, 65535), $urandom_range(0, 65535));
                default: set_gains($urandom(), 32'hFFFF_FFFF);
            endcase
            idle_on = (phase != 2);
            repeat (PHASE_ITEMS) send_random_request();
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n         = 1'b1;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_UPDATE;
        cfg_we        = 1'b0;
        cfg_index     = CFG_METRE_GAIN;
        cfg_data      = '0;
        for (int k = 0; k < 4; k++)
        begin
            odo_last_count[k] = '0;
            enc_count[k]      = '0;
        end
        odo_x       = '0;
        odo_y       = '0;
        odo_heading = '0;

        // give the asynchronous reset a clean falling edge before the first clock
        #1 rst_n = 1'b0;

        // reset once, released away from the rising edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        idle_on = 1'b1;
        test_zero_gain();
        test_spare_index();
        test_counter_wrap();
        test_heading_wrap();
        test_pose_saturation();
        test_clear();
        test_backpressure();
        idle_on = 1'b1;
        test_random_traffic();

        // drain, then leave room for any stray result to show up
        wait_drained();
        repeat (2 * UPDATE_LATENCY) @(posedge clk);
        if (pending_pose.size() != 0)
        begin
            mismatch_count += pending_pose.size();
            $display("%0d results never arrived", pending_pose.size());
        end

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/mcodo_pkg.sv
src/mcodo_mac.sv
src/mcodo_cordic.sv
src/mecanum_encoder_odometry.sv
src/mcodo_checker.sv
test/tb_top.sv
